// ----- sv/mcst_pkg.sv -----
// package: shared constants, opcodes and controller/datapath command types
`default_nettype none
package mcst_pkg;
  localparam int MAX_TIMERS   = 16;
  localparam int TIMEOUT_BITS = 24;
  localparam int IDX_W        = $clog2(MAX_TIMERS);
  localparam int CNT_W        = $clog2(MAX_TIMERS + 1);
  localparam int ID_W         = 16;
  localparam int OP_W         = 4;
  localparam int OUT_TMO_W    = 24;

  localparam logic [OP_W-1:0] OP_TICK      = 4'd0;
  localparam logic [OP_W-1:0] OP_CREATE    = 4'd1;
  localparam logic [OP_W-1:0] OP_REMOVE    = 4'd2;
  localparam logic [OP_W-1:0] OP_SET       = 4'd3;
  localparam logic [OP_W-1:0] OP_START     = 4'd4;
  localparam logic [OP_W-1:0] OP_START_TMO = 4'd5;
  localparam logic [OP_W-1:0] OP_START_MODE = 4'd6;
  localparam logic [OP_W-1:0] OP_STOP      = 4'd7;
  localparam logic [OP_W-1:0] OP_READ      = 4'd8;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [ID_W-1:0]         tid;
    logic [23:0]             timeout_ms;
    logic                    periodic_flag;
  } item_t;

  typedef struct packed {
    logic                 result_kind;
    logic [ID_W-1:0]      reply_id;
    logic [OUT_TMO_W-1:0] reply_timeout;
    logic                 ok;
    logic                 last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;      // capture input item, reset scan
    logic             step;      // process slot at scan index
    logic             finish;    // apply command / build reply or last expiry
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;             // scan index past last used slot, id found, or no scan needed
    logic emit;                  // a result is ready this step
  } dp_sts_t;

  // nonzero multiple-of-ten check: quotient by reciprocal multiply (exact for 24 bits), then multiply back
  function automatic logic tmo_valid(input logic [23:0] t);
    logic [47:0] prod;
    logic [20:0] q;
    logic [23:0] back;
    prod = 48'(t) * 48'(24'hCCCCCD);
    q    = prod[47:27];
    back = {q, 3'b000} + {2'b00, q, 1'b0};
    return (t != '0) && (back == t);
  endfunction
endpackage
`default_nettype wire

// ----- sv/mcst_if.sv -----
// handshake channel interface
`default_nettype none
interface mcst_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/multi_channel_soft_timer_table.sv -----
// top level: timer table with command/tick input and reply/expiry output
// Timer table of 16 entries kept in creation order. Each input transfer is a
// command or a 1 ms tick. The block takes one item at a time: the controller
// scans the used slots one per cycle, pausing while the output side stalls. A
// tick emits one expiry transfer per expiring slot, the final one flagged
// last; a tick with no expiry emits nothing. Every command emits exactly one reply.
`default_nettype none
module multi_channel_soft_timer_table (
  input  wire logic clk,
  input  wire logic rst_n,
  mcst_if.sink      in_ch,
  mcst_if.source    out_ch
);
  mcst_pkg::dp_cmd_t cmd;
  mcst_pkg::dp_sts_t sts;
  logic out_busy;

  // sequencing of load / slot scan / finish
  mcst_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_busy (out_busy),
    .cmd, .sts
  );

  // table storage and result register
  mcst_dp u_dp (
    .clk, .rst_n,
    .in_item   (in_ch.data),
    .cmd, .sts,
    .out_busy  (out_busy),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
  );
endmodule
`default_nettype wire

// ----- sv/mcst_ctrl.sv -----
// controller state machine
`default_nettype none
module mcst_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            out_busy,
  output mcst_pkg::dp_cmd_t    cmd,
  input  wire mcst_pkg::dp_sts_t sts
);
  localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_FIN = 2'd2;
  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_FIN;
        else if (!(sts.emit && out_busy)) cmd.step = 1'b1;
      end
      S_FIN: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ----- sv/mcst_dp.sv -----
// datapath: timer table, slot scan and result register
`default_nettype none
module mcst_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mcst_pkg::item_t     in_item,
  input  wire mcst_pkg::dp_cmd_t   cmd,
  output mcst_pkg::dp_sts_t        sts,
  output logic                     out_busy,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mcst_pkg::result_t        out_data
);
  localparam int N  = mcst_pkg::MAX_TIMERS;
  localparam int TW = mcst_pkg::TIMEOUT_BITS;
  localparam int IW = mcst_pkg::IDX_W;
  localparam int CW = mcst_pkg::CNT_W;
  localparam int HW = mcst_pkg::ID_W;
  localparam logic [TW-1:0] TMAX = '1;

  logic [HW-1:0] sid_r  [N];
  logic [TW-1:0] dflt_r [N];
  logic [TW-1:0] cur_r  [N];
  logic [TW-1:0] el_r   [N];
  logic [N-1:0]  run_r, per_r;
  logic [CW-1:0] used_r;
  logic [HW-1:0] last_id_r;

  mcst_pkg::item_t   it_r;
  logic [CW-1:0]     idx_r;      // scan position
  logic              found_r, tmo_ok_r, pend_r, have_r;
  logic [IW-1:0]     hit_r;
  logic [TW-1:0]     hit_tmo_r;
  mcst_pkg::result_t res_r, pend_res_r;
  logic              res_v_r;

  logic [IW-1:0] ix;
  logic          is_tick, fire;
  logic [TW-1:0] el_inc;
  logic [TW-1:0] tmo_in;
  logic [HW-1:0] nid;
  logic [IW-1:0] wr_ix;
  logic          create_ok, found_ok;
  logic [N-1:0]  keep_mask;
  mcst_pkg::result_t fin_res;

  assign ix      = idx_r[IW-1:0];
  assign is_tick = (it_r.op == mcst_pkg::OP_TICK);
  assign el_inc  = (el_r[ix] < TMAX) ? el_r[ix] + 1'b1 : el_r[ix];
  assign fire    = is_tick && run_r[ix] && (el_inc >= cur_r[ix]);
  assign tmo_in  = TW'(it_r.timeout_ms);

  // id counter skips 0 on wrap
  assign nid       = (last_id_r == '1) ? HW'(1) : last_id_r + 1'b1;
  assign wr_ix     = used_r[IW-1:0];
  assign create_ok = tmo_ok_r && (used_r < CW'(N));
  assign found_ok  = found_r && (it_r.op <= mcst_pkg::OP_READ) &&
                     !(it_r.op == mcst_pkg::OP_SET && !tmo_ok_r);

  // slots below the removed one stay in place
  always_comb begin
    for (int k = 0; k < N; k++) keep_mask[k] = (IW'(k) < hit_r);
  end

  // remove shifts: search phase stops at the matching slot, then shift phase
  logic search_stop;
  assign search_stop = !is_tick && found_r;
  always_comb begin
    sts.emit      = fire && (idx_r < used_r) && pend_r;
    sts.scan_done = (idx_r >= used_r) || search_stop ||
                    (it_r.op > mcst_pkg::OP_READ) || (it_r.op == mcst_pkg::OP_CREATE);
  end

  // final result of an item: last expiry of a tick, or the command reply
  always_comb begin
    if (is_tick) begin
      fin_res      = pend_res_r;
      fin_res.last = 1'b1;
    end else begin
      fin_res.result_kind   = mcst_pkg::KIND_REPLY;
      fin_res.reply_id      = it_r.tid;
      fin_res.reply_timeout = '0;
      fin_res.ok            = found_ok;
      fin_res.last          = 1'b1;
      if (it_r.op == mcst_pkg::OP_CREATE) begin
        fin_res.reply_id = create_ok ? nid : '0;
        fin_res.ok       = create_ok;
      end else if (it_r.op == mcst_pkg::OP_READ && found_ok) begin
        fin_res.reply_timeout = mcst_pkg::OUT_TMO_W'(hit_tmo_r);
      end
    end
  end

  assign out_busy  = res_v_r && !out_ready;
  assign out_valid = res_v_r;
  assign out_data  = res_r;

  // pending expiry kept one step back so the last one can be marked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0; have_r <= 1'b0; found_r <= 1'b0;
    end else if (cmd.load) begin
      it_r     <= in_item;
      idx_r    <= '0;
      found_r  <= 1'b0;
      have_r   <= 1'b0;
      pend_r   <= 1'b1;
      tmo_ok_r <= mcst_pkg::tmo_valid(in_item.timeout_ms);
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
      if (is_tick) begin
        if (fire) begin
          have_r     <= 1'b1;
          pend_res_r <= '{mcst_pkg::KIND_EXPIRY, sid_r[ix], '0, 1'b1, 1'b0};
        end
      end else if (sid_r[ix] == it_r.tid) begin
        found_r   <= 1'b1;
        hit_r     <= ix;
        hit_tmo_r <= cur_r[ix];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (cmd.finish) begin
      res_v_r <= !is_tick || have_r;
      res_r   <= fin_res;
    end else if (cmd.step && fire && have_r) begin
      res_v_r <= 1'b1;
      res_r   <= pend_res_r;
    end else if (out_ready) begin
      res_v_r <= 1'b0;
    end
  end

  // timer table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0; per_r <= '0; used_r <= '0; last_id_r <= '0;
    end else if (cmd.step && is_tick) begin
      if (fire) begin
        cur_r[ix] <= dflt_r[ix];
        el_r[ix]  <= '0;
        if (!per_r[ix]) run_r[ix] <= 1'b0;
      end else begin
        el_r[ix] <= el_inc;
      end
    end else if (cmd.finish && !is_tick) begin
      if (it_r.op == mcst_pkg::OP_CREATE) begin
        if (create_ok) begin
          last_id_r     <= nid;
          sid_r[wr_ix]  <= nid;
          dflt_r[wr_ix] <= tmo_in;
          cur_r[wr_ix]  <= tmo_in;
          el_r[wr_ix]   <= '0;
          run_r[wr_ix]  <= 1'b0;
          per_r[wr_ix]  <= 1'b0;
          used_r <= used_r + 1'b1;
        end
      end else if (found_ok) begin
        unique case (it_r.op)
          mcst_pkg::OP_REMOVE: begin
            for (int k = 0; k < N - 1; k++)
              if (IW'(k) >= hit_r) begin
                sid_r[k] <= sid_r[k+1]; dflt_r[k] <= dflt_r[k+1];
                cur_r[k] <= cur_r[k+1]; el_r[k] <= el_r[k+1];
              end
            // free slots hold run and periodic at zero, so the shift clears the top one
            run_r  <= (run_r & keep_mask) | ((run_r >> 1) & ~keep_mask);
            per_r  <= (per_r & keep_mask) | ((per_r >> 1) & ~keep_mask);
            used_r <= used_r - 1'b1;
          end
          mcst_pkg::OP_SET: begin
            dflt_r[hit_r] <= tmo_in; cur_r[hit_r] <= tmo_in; el_r[hit_r] <= '0;
          end
          mcst_pkg::OP_START: begin
            run_r[hit_r] <= 1'b1; el_r[hit_r] <= '0;
          end
          mcst_pkg::OP_START_TMO: begin
            run_r[hit_r] <= 1'b1; cur_r[hit_r] <= tmo_in; el_r[hit_r] <= '0;
          end
          mcst_pkg::OP_START_MODE: begin
            run_r[hit_r] <= 1'b1; per_r[hit_r] <= it_r.periodic_flag;
            el_r[hit_r] <= '0;
          end
          mcst_pkg::OP_STOP: run_r[hit_r] <= 1'b0;
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire
